/* sv/dvi_ss_pkg.sv */
// Package for the DVI scanline sequencer: item structs, list kinds, op codes,
// configuration register indexes and word counts. No dependencies.
`timescale 1ns / 1ps

package dvi_ss_pkg;

  typedef enum logic {
    OP_XFER_DONE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_SYNC_ON  = 2'd0,
    KIND_SYNC_OFF = 2'd1,
    KIND_COMMANDS = 2'd2,
    KIND_PIXELS   = 2'd3
  } list_kind_e;

  typedef enum logic [2:0] {
    REG_DIM_ENABLE   = 3'd0,
    REG_FRONT_PORCH  = 3'd1,
    REG_SYNC_LINES   = 3'd2,
    REG_BACK_PORCH   = 3'd3,
    REG_ACTIVE_LINES = 3'd4,
    REG_ACTIVE_PIX   = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam logic [9:0] BlankWords = 10'd7;
  localparam logic [9:0] CmdWords   = 10'd9;

  // Register reset values
  localparam logic [7:0]  RstFrontPorch  = 8'd1;
  localparam logic [7:0]  RstSyncLines   = 8'd3;
  localparam logic [7:0]  RstBackPorch   = 8'd16;
  localparam logic [9:0]  RstActiveLines = 10'd480;
  localparam logic [10:0] RstActivePix   = 11'd640;
  localparam logic [10:0] RstScanline    = 11'd2;

  typedef struct packed {
    op_e         op;
    logic [15:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic        reload_channel;
    list_kind_e  list_kind;
    logic [9:0]  transfer_words;
    logic        line_buffer_sel;
    logic        in_vblank;
    logic [31:0] frame_count;
    logic        load_valid;
    logic [8:0]  load_row;
    logic        load_buffer;
    logic        load_dim;
    logic [31:0] pixel_word;
  } out_item_t;

endpackage

/* sv/dvi_scanline_sequencer.sv */
// Top level of the DVI scanline sequencer: vertical line sequencing for a
// ping-pong scanout and the RGB555 dimming pixel path. Uses dvi_ss_pkg.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    dvi_ss_pkg::in_item_t
// out      output     out_valid_o / out_stall_i  dvi_ss_pkg::out_item_t
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while in_stall_o is low. The item is handled
// by one pass of logic into the output register, or into the skid register
// while the output is stalled; the state registers update on the same edge,
// so back-to-back items chain. The skid catches one result; in_stall_o
// rises only when the skid is full. Reset is asynchronous, active low, and
// brings the timing registers to 1/3/16/480/640 and the scanline to 2.
module dvi_scanline_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  dvi_ss_pkg::in_item_t                 in_data_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output dvi_ss_pkg::out_item_t                out_data_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dvi_ss_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dvi_ss_pkg::CfgDataW-1:0]      cfg_data_i
);
  import dvi_ss_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers, plus derived line sums kept in registers.
  // The sums are loaded from the next register values, so they update on
  // the same edge as the registers they are summed from.
  // ---------------------------------------------------------------------
  logic        dim_q,   dim_d;
  logic [7:0]  fp_q,    fp_d;
  logic [7:0]  sync_q,  sync_d;
  logic [7:0]  bp_q,    bp_d;
  logic [9:0]  al_q,    al_d;
  logic [10:0] ap_q,    ap_d;
  logic [8:0]  fs_q,    fs_d;     // front + sync
  logic [9:0]  blank_q, blank_d;  // front + sync + back
  logic [10:0] total_q, total_d;  // blank + active lines
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    dim_d  = dim_q;
    fp_d   = fp_q;
    sync_d = sync_q;
    bp_d   = bp_q;
    al_d   = al_q;
    ap_d   = ap_q;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DIM_ENABLE:   dim_d  = cfg_data_i[0];
        REG_FRONT_PORCH:  fp_d   = cfg_data_i[7:0];
        REG_SYNC_LINES:   sync_d = cfg_data_i[7:0];
        REG_BACK_PORCH:   bp_d   = cfg_data_i[7:0];
        REG_ACTIVE_LINES: al_d   = cfg_data_i[9:0];
        REG_ACTIVE_PIX:   ap_d   = cfg_data_i[10:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
    fs_d    = {1'b0, fp_d} + {1'b0, sync_d};
    blank_d = {1'b0, fs_d} + {2'b00, bp_d};
    total_d = {1'b0, blank_d} + {1'b0, al_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= 1'b0;
      fp_q    <= RstFrontPorch;
      sync_q  <= RstSyncLines;
      bp_q    <= RstBackPorch;
      al_q    <= RstActiveLines;
      ap_q    <= RstActivePix;
      fs_q    <= {1'b0, RstFrontPorch} + {1'b0, RstSyncLines};
      blank_q <= {2'b00, RstFrontPorch} + {2'b00, RstSyncLines} + {2'b00, RstBackPorch};
      total_q <= {3'b000, RstFrontPorch} + {3'b000, RstSyncLines}
               + {3'b000, RstBackPorch} + {1'b0, RstActiveLines};
    end else begin
      dim_q   <= dim_d;
      fp_q    <= fp_d;
      sync_q  <= sync_d;
      bp_q    <= bp_d;
      al_q    <= al_d;
      ap_q    <= ap_d;
      fs_q    <= fs_d;
      blank_q <= blank_d;
      total_q <= total_d;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: output register plus one skid entry.
  // ---------------------------------------------------------------------
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      in_fire, out_fire;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  logic [10:0] scan_q,   scan_d;
  logic        pong_q,   pong_d;
  logic        cmd_q,    cmd_d;
  logic        vb_q,     vb_d;
  logic [31:0] frames_q, frames_d;

  // visibility of the current scanline (pixel dimming)
  logic [10:0] cur_off;
  logic        cur_vis;
  // next scanline and its visibility (load request)
  logic [11:0] nx;
  logic [10:0] new_off;
  logic        new_vis;
  logic        advance;
  logic [15:0] pix;
  out_item_t   res;

  assign cur_off = scan_q - {1'b0, blank_q};
  assign cur_vis = (scan_q >= {1'b0, blank_q}) && (cur_off < {1'b0, al_q});

  always_comb begin
    res      = '0;
    scan_d   = scan_q;
    pong_d   = pong_q;
    cmd_d    = cmd_q;
    vb_d     = vb_q;
    frames_d = frames_q;
    nx       = '0;
    new_off  = '0;
    new_vis  = 1'b0;
    advance  = 1'b0;
    pix      = in_data_i.pixel_in;

    if (in_data_i.op == OP_PIXEL) begin
      // odd visible line with dimming: halve each 5-bit component, drop bit 15
      if (dim_q && cur_vis && cur_off[0]) begin
        pix = {2'b00, in_data_i.pixel_in[14:11], 1'b0, in_data_i.pixel_in[9:6],
               1'b0, in_data_i.pixel_in[4:1]};
      end
      res.pixel_word = {pix, pix};
    end else begin
      res.reload_channel = pong_q;
      pong_d             = ~pong_q;
      if (scan_q >= {3'b000, fp_q} && scan_q < {2'b00, fs_q}) begin
        res.list_kind      = KIND_SYNC_ON;
        res.transfer_words = BlankWords;
        vb_d               = 1'b1;
      end else if (scan_q < {1'b0, blank_q}) begin
        res.list_kind      = KIND_SYNC_OFF;
        res.transfer_words = BlankWords;
        vb_d               = 1'b1;
      end else if (!cmd_q) begin
        res.list_kind      = KIND_COMMANDS;
        res.transfer_words = CmdWords;
        cmd_d              = 1'b1;
        vb_d               = 1'b0;
      end else begin
        res.list_kind       = KIND_PIXELS;
        res.transfer_words  = ap_q[10:1];
        res.line_buffer_sel = scan_q[0];
        cmd_d               = 1'b0;
      end

      // every list ends the scanline unless the command flag is set (after the command list)
      advance = ~cmd_d;
      if (advance) begin
        nx = {1'b0, scan_q} + 12'd1;
        // compare-and-clear also covers a scanline left past the total
        if (nx >= {1'b0, total_q}) begin
          nx = '0;
        end
        scan_d = nx[10:0];
        if (scan_d == '0) begin
          frames_d = frames_q + 32'd1;
        end
        new_off = scan_d - {1'b0, blank_q};
        new_vis = (scan_d >= {1'b0, blank_q}) && (new_off < {1'b0, al_q});
        if (new_vis) begin
          res.load_valid  = 1'b1;
          res.load_row    = new_off[9:1];
          res.load_buffer = scan_d[0];
          res.load_dim    = dim_q & new_off[0];
        end
      end
    end
    res.in_vblank   = vb_d;
    res.frame_count = frames_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= RstScanline;
      pong_q   <= 1'b0;
      cmd_q    <= 1'b0;
      vb_q     <= 1'b0;
      frames_q <= '0;
    end else if (in_fire) begin
      scan_q   <= scan_d;
      pong_q   <= pong_d;
      cmd_q    <= cmd_d;
      vb_q     <= vb_d;
      frames_q <= frames_d;
    end
  end

  // output / skid steering
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without a valid output");

  // pixel transfers never touch the line sequencing state
  a_pixel_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.op == OP_PIXEL) |=>
      ($stable(scan_q) && $stable(pong_q) && $stable(frames_q) && $stable(cmd_q)))
    else $error("pixel transfer changed sequencer state");

  // a transfer-done always swaps the ping-pong channel
  a_pong_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.op == OP_XFER_DONE) |=> (pong_q != $past(pong_q)))
    else $error("channel did not alternate");

endmodule

/* tb/tb_dvi_scanline_sequencer.sv */
// Self-checking testbench for dvi_scanline_sequencer: line sequencing, frame
// counting, load requests and the dimming pixel path. Uses dvi_ss_pkg.
`timescale 1ns / 1ps

module tb_dvi_scanline_sequencer;
  import dvi_ss_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 600;

  // Receiver stall patterns; the receiver switches between them on its own.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  dvi_scanline_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: timing registers as the block should hold them, and the
  // line sequencing state.
  // ---------------------------------------------------------------------------
  logic        t_dim_en;
  logic [7:0]  t_front;
  logic [7:0]  t_sync;
  logic [7:0]  t_back;
  logic [9:0]  t_lines;
  logic [10:0] t_pixels;

  logic [10:0] sl_line;
  logic        sl_pong;
  logic        sl_cmds_out;
  logic        sl_vblank;
  logic [31:0] sl_frames;

  in_item_t    pending_items[$];   // items waiting for the driver
  out_item_t   predicted_outs[$];  // results owed by the block, oldest first

  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  bit          in_xfer = 1'b0;     // input transfer seen at the last rising edge
  out_item_t   want;

  // Sender burst bookkeeping
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  // Receiver: pattern, and long hold-offs asked for by the stimulus
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;

  function automatic int unsigned blank_lines();
    return int'(t_front) + int'(t_sync) + int'(t_back);
  endfunction

  // Visible line index of a scanline, -1 in blanking or past the active area
  function automatic int visible_line(logic [10:0] s);
    int unsigned b;
    b = blank_lines();
    if (s < b) return -1;
    if (s - b >= t_lines) return -1;
    return int'(s - b);
  endfunction

  // Expected result of one item; advances the line state on transfer-done.
  function automatic out_item_t sequence_item(in_item_t it);
    out_item_t   r;
    int unsigned total, nx;
    int          vis;
    logic [15:0] c;
    r = '0;
    if (it.op == OP_PIXEL) begin
      vis = visible_line(sl_line);
      c = it.pixel_in;
      // dimmed lines halve each 5-bit component; bit 15 drops out
      if (t_dim_en && vis >= 0 && vis[0])
        c = {1'b0, c[14:10] >> 1, c[9:5] >> 1, c[4:0] >> 1};
      r.in_vblank  = sl_vblank;
      r.frame_count = sl_frames;
      r.pixel_word = {c, c};
    end else begin
      r.reload_channel = sl_pong;
      sl_pong = ~sl_pong;
      total = blank_lines() + t_lines;
      if (sl_line >= t_front && sl_line < int'(t_front) + int'(t_sync)) begin
        r.list_kind = KIND_SYNC_ON;
        r.transfer_words = BlankWords;
        sl_vblank = 1'b1;
      end else if (sl_line < blank_lines()) begin
        r.list_kind = KIND_SYNC_OFF;
        r.transfer_words = BlankWords;
        sl_vblank = 1'b1;
      end else if (!sl_cmds_out) begin
        r.list_kind = KIND_COMMANDS;
        r.transfer_words = CmdWords;
        sl_cmds_out = 1'b1;
        sl_vblank = 1'b0;
      end else begin
        r.list_kind = KIND_PIXELS;
        r.transfer_words = t_pixels[10:1];
        r.line_buffer_sel = sl_line[0];
        sl_cmds_out = 1'b0;
      end
      // the line holds while the command flag is set (after the command list); else it moves on
      if (!sl_cmds_out) begin
        nx = sl_line + 1;
        if (nx >= total) nx = 0;   // also catches a line left past a shrunk frame
        sl_line = nx[10:0];
        if (sl_line == '0) sl_frames = sl_frames + 1;
        vis = visible_line(sl_line);
        if (vis >= 0) begin
          r.load_valid = 1'b1;
          r.load_row = 9'(vis >> 1);
          r.load_buffer = sl_line[0];
          r.load_dim = t_dim_en && vis[0];
        end
      end
      r.in_vblank = sl_vblank;
      r.frame_count = sl_frames;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Output transfers are checked before the input
  // transfer of the same edge is predicted, so the oldest entry is matched.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      in_xfer = rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (predicted_outs.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual %h", $time, out_data_o);
        end else begin
          want = predicted_outs.pop_front();
          check_field("reload_channel", 32'(want.reload_channel),
                      32'(out_data_o.reload_channel));
          check_field("list_kind", 32'(want.list_kind), 32'(out_data_o.list_kind));
          check_field("transfer_words", 32'(want.transfer_words),
                      32'(out_data_o.transfer_words));
          check_field("line_buffer_sel", 32'(want.line_buffer_sel),
                      32'(out_data_o.line_buffer_sel));
          check_field("in_vblank", 32'(want.in_vblank), 32'(out_data_o.in_vblank));
          check_field("frame_count", want.frame_count, out_data_o.frame_count);
          check_field("load_valid", 32'(want.load_valid), 32'(out_data_o.load_valid));
          check_field("load_row", 32'(want.load_row), 32'(out_data_o.load_row));
          check_field("load_buffer", 32'(want.load_buffer), 32'(out_data_o.load_buffer));
          check_field("load_dim", 32'(want.load_dim), 32'(out_data_o.load_dim));
          check_field("pixel_word", want.pixel_word, out_data_o.pixel_word);
        end
      end
      if (in_xfer) begin
        predicted_outs.push_back(sequence_item(in_data_i));
        accepted_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge. A new item goes out only once the current one has
  // transferred; the sender runs in bursts, mostly with idle gaps between them.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          // a quarter of the bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: falling edge. Changes stall pattern when its mode count runs
  // out and serves long hold-offs so the skid fills and the input stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = $urandom_range(40, 80);
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 2) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t pixel_item(logic [15:0] p);
    in_item_t it;
    it.op = OP_PIXEL;
    it.pixel_in = p;
    return it;
  endfunction

  // pixel field is junk on transfer-done items; the block must ignore it
  function automatic in_item_t done_item();
    in_item_t it;
    it.op = OP_XFER_DONE;
    it.pixel_in = 16'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] any_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // porch or sync width at an extreme: zero, full scale or anything
  function automatic logic [7:0] extreme_lines();
    if ($urandom_range(0, 2) == 0) return 8'd0;
    if ($urandom_range(0, 1) != 0) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic push_item(in_item_t it);
    pending_items.push_back(it);
    pushed_cnt++;
  endtask

  // Sender pause: every item transferred and every result back.
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || predicted_outs.size() != 0)
      @(negedge clk_i);
  endtask

  // One register write; the predictor copy changes on the transfer edge.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_DIM_ENABLE:   t_dim_en = val[0];
      REG_FRONT_PORCH:  t_front  = val[7:0];
      REG_SYNC_LINES:   t_sync   = val[7:0];
      REG_BACK_PORCH:   t_back   = val[7:0];
      REG_ACTIVE_LINES: t_lines  = val[9:0];
      REG_ACTIVE_PIX:   t_pixels = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [10:0] dim, logic [10:0] fp, logic [10:0] sy,
                            logic [10:0] bp, logic [10:0] al, logic [10:0] ap);
    write_reg(REG_DIM_ENABLE, dim);
    write_reg(REG_FRONT_PORCH, fp);
    write_reg(REG_SYNC_LINES, sy);
    write_reg(REG_BACK_PORCH, bp);
    write_reg(REG_ACTIVE_LINES, al);
    write_reg(REG_ACTIVE_PIX, ap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly tiny frames so lines and frames wrap often; some phases take the
  // register extremes. In extreme phases, and for the dim bit, bits above a register's width carry junk.
  task automatic pick_timing(bit extreme);
    logic [10:0] fp, sy, bp, al, ap;
    logic [2:0]  junk;
    junk = 3'($urandom);
    if (extreme) begin
      fp = {junk, extreme_lines()};
      sy = {junk, extreme_lines()};
      bp = {junk, extreme_lines()};
      case ($urandom_range(0, 5))
        0:       al = {junk[0], 10'd0};
        1:       al = {junk[0], 10'd1};
        2:       al = {junk[0], 10'd2};
        3:       al = {junk[0], 10'd1022};
        4:       al = {junk[0], 10'd1023};
        default: al = 11'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       ap = 11'd0;
        1:       ap = 11'd1;
        2:       ap = 11'd2;
        3:       ap = 11'd2046;
        4:       ap = 11'd2047;
        default: ap = 11'($urandom);
      endcase
    end else begin
      fp = 11'($urandom_range(0, 3));
      sy = 11'($urandom_range(0, 3));
      bp = 11'($urandom_range(0, 3));
      al = 11'($urandom_range(0, 12));
      ap = 11'($urandom);
    end
    set_timing(11'($urandom), fp, sy, bp, al, ap);
  endtask

  // Scanline-shaped traffic: a transfer-done then a run of pixels, with an
  // occasional stray run of done events or pixels.
  task automatic queue_lines(int unsigned n);
    int unsigned k;
    int unsigned run;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          push_item($urandom_range(0, 1) ? done_item() : pixel_item(any_pixel()));
          k++;
        end
      end else begin
        push_item(done_item());
        k++;
        run = $urandom_range(0, 5);
        repeat (run) begin
          push_item(pixel_item(any_pixel()));
          k++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_sent;
    int unsigned phase;
    random_sent = 0;
    phase = 0;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DIM_ENABLE;
    cfg_data_i  = '0;

    t_dim_en = 1'b0;
    t_front  = RstFrontPorch;
    t_sync   = RstSyncLines;
    t_back   = RstBackPorch;
    t_lines  = RstActiveLines;
    t_pixels = RstActivePix;
    sl_line     = RstScanline;
    sl_pong     = 1'b0;
    sl_cmds_out = 1'b0;
    sl_vblank   = 1'b0;
    sl_frames   = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset timing: pixel extremes, then done events walk the line from sync
    // through back porch into the first visible line (commands, then pixels).
    push_item(pixel_item(16'h0000));
    push_item(pixel_item(16'hFFFF));
    push_item(pixel_item(16'h8000));
    push_item(pixel_item(16'h7FFF));
    repeat (20) push_item(done_item());
    push_item(pixel_item(16'hFFFF));
    wait_drained();

    // Minimal frame with dimming: the line sits past the new total and must
    // wrap, then odd visible lines darken the pixel path.
    set_timing(11'd1, 11'd0, 11'd1, 11'd0, 11'd2, 11'd2046);
    push_item(done_item());
    push_item(done_item());
    push_item(pixel_item(16'hFFFF));
    push_item(done_item());
    push_item(pixel_item(16'h7FFF));
    push_item(done_item());
    push_item(pixel_item(16'h5555));
    push_item(done_item());
    push_item(pixel_item(16'hAAAA));
    push_item(done_item());
    push_item(pixel_item(16'hFFFF));
    push_item(done_item());
    push_item(pixel_item(16'h8000));
    wait_drained();

    // Zero total: every advance wraps to line 0 and counts a frame.
    set_timing(11'd1, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1);
    repeat (4) push_item(done_item());
    push_item(pixel_item(16'hFFFF));
    wait_drained();

    // Random phases. Every fourth phase (and the second) starts with a long
    // receiver hold-off while the sender keeps offering items.
    while (random_sent < RandomItems) begin
      pick_timing(phase == 0 || $urandom_range(0, 4) == 0);
      if (phase == 1 || phase % 4 == 3) hold_asked++;
      queue_lines(40 + $urandom_range(0, 50));
      random_sent = pushed_cnt;
      random_sent = random_sent > 60 ? random_sent - 60 : 0;
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/dvi_ss_pkg.sv
sv/dvi_scanline_sequencer.sv
tb/tb_dvi_scanline_sequencer.sv
